FILE: sv/cbsc_pkg.sv
// Shared types and constants for the cruise button speed control block.
package cbsc_pkg;

    localparam int unsigned CFG_WIDTH   = 14;
    localparam int unsigned SPEED_WIDTH = 16;
    localparam int unsigned CMD_WIDTH   = 15;
    localparam int unsigned REGEN_WIDTH = 2;
    localparam int unsigned IDX_WIDTH   = 2;

    // Register indexes on the configuration channel
    localparam logic [IDX_WIDTH-1:0] CFG_TARGET_STEP    = 2'd0;
    localparam logic [IDX_WIDTH-1:0] CFG_RAMP_UP_RATE   = 2'd1;
    localparam logic [IDX_WIDTH-1:0] CFG_RAMP_DOWN_RATE = 2'd2;

    localparam logic signed [17:0] ENGAGE_MIN = 18'sd500;
    localparam logic signed [17:0] SAT_HIGH   = 18'sd32767;
    localparam logic signed [17:0] SAT_LOW    = -18'sd32768;
    localparam logic [REGEN_WIDTH-1:0] REGEN_MAX = 2'd3;

    typedef struct packed {
        logic                          btn_on;
        logic                          btn_set_plus;
        logic                          btn_set_minus;
        logic                          btn_disable;
        logic                          brake_pressed;
        logic                          run_mode;
        logic signed [SPEED_WIDTH-1:0] vehicle_speed;
    } in_word_t;

    typedef struct packed {
        logic [CMD_WIDTH-1:0]   cruise_speed;
        logic [REGEN_WIDTH-1:0] regen_level;
    } out_word_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] target_step;
        logic [CFG_WIDTH-1:0] ramp_up_rate;
        logic [CFG_WIDTH-1:0] ramp_down_rate;
    } cfg_t;

endpackage

FILE: sv/cbsc_if.sv
// Handshake channel interfaces for tick words, result words and register writes.
interface cbsc_in_if;
    logic               valid;
    logic               ready;
    cbsc_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
    modport mon    (input valid, input data, input ready);
endinterface

interface cbsc_out_if;
    logic                valid;
    logic                ready;
    cbsc_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
    modport mon    (input valid, input data, input ready);
endinterface

interface cbsc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cbsc_pkg::IDX_WIDTH-1:0]   index;
    logic [cbsc_pkg::CFG_WIDTH-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
    modport mon    (input valid, input index, input data, input ready);
endinterface

FILE: sv/cbsc_core.sv
// Cruise state registers and the single-pass update for one tick word.
module cbsc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  cbsc_pkg::in_word_t  word,
    input  cbsc_pkg::cfg_t      cfg,
    output cbsc_pkg::out_word_t res
);

    logic                                  latched_reg;
    logic                                  latched_next;
    logic signed [cbsc_pkg::SPEED_WIDTH-1:0] target_reg;
    logic signed [cbsc_pkg::SPEED_WIDTH-1:0] target_next;
    logic [cbsc_pkg::CMD_WIDTH-1:0]        cmd_reg;
    logic [cbsc_pkg::CMD_WIDTH-1:0]        cmd_next;
    logic [cbsc_pkg::REGEN_WIDTH-1:0]      regen_reg;
    logic [cbsc_pkg::REGEN_WIDTH-1:0]      regen_next;

    always_comb
    begin
        logic signed [17:0] speed;
        logic signed [17:0] tgt;
        logic signed [17:0] cs;
        logic signed [17:0] step;
        logic signed [17:0] sum;
        logic               setp;
        logic               setn;

        setp  = word.btn_set_plus;
        setn  = word.btn_set_minus;
        speed = {{2{word.vehicle_speed[15]}}, word.vehicle_speed};
        tgt   = {{2{target_reg[15]}}, target_reg};
        cs    = {3'b000, cmd_reg};
        step  = {4'b0000, cfg.target_step};
        sum   = '0;

        latched_next = latched_reg;
        target_next  = target_reg;
        cmd_next     = cmd_reg;
        regen_next   = regen_reg;

        if (latched_reg)
        begin
            // hold everything until both set buttons are released
            if (!setp && !setn)
            begin
                latched_next = 1'b0;
            end
        end
        else
        begin
            if (setp || setn)
            begin
                latched_next = 1'b1;
            end

            if (word.brake_pressed)
            begin
                if (setp)
                begin
                    if (regen_reg < cbsc_pkg::REGEN_MAX)
                    begin
                        regen_next = regen_reg + 2'd1;
                    end
                end
                else if (setn)
                begin
                    if (regen_reg != '0)
                    begin
                        regen_next = regen_reg - 2'd1;
                    end
                end
            end

            if (word.btn_on && word.run_mode)
            begin
                if (cs <= 18'sd0)
                begin
                    if (setn && speed > cbsc_pkg::ENGAGE_MIN)
                    begin
                        tgt = speed;
                        cs  = speed;
                    end
                    else if (setp && tgt > 18'sd0)
                    begin
                        cs = speed;
                    end
                end
                else
                begin
                    if (word.btn_disable || word.brake_pressed)
                    begin
                        cs = '0;
                    end
                    else if (setp || setn)
                    begin
                        sum = setp ? (tgt + step) : (tgt - step);
                        if (sum > cbsc_pkg::SAT_HIGH)
                        begin
                            tgt = cbsc_pkg::SAT_HIGH;
                        end
                        else if (sum < cbsc_pkg::SAT_LOW)
                        begin
                            tgt = cbsc_pkg::SAT_LOW;
                        end
                        else
                        begin
                            tgt = sum;
                        end
                    end
                end
            end
            else
            begin
                cs  = '0;
                tgt = '0;
            end

            // ramp toward the target, clamped at the target and at zero
            if (cs <= 18'sd0)
            begin
                cs = '0;
            end
            else if (cs < tgt)
            begin
                cs = cs + {4'b0000, cfg.ramp_up_rate};
                if (cs > tgt)
                begin
                    cs = tgt;
                end
            end
            else if (cs > tgt)
            begin
                cs = cs - {4'b0000, cfg.ramp_down_rate};
                if (cs < tgt)
                begin
                    cs = tgt;
                end
                if (cs < 18'sd0)
                begin
                    cs = '0;
                end
            end
            if (cs > cbsc_pkg::SAT_HIGH)
            begin
                cs = cbsc_pkg::SAT_HIGH;
            end

            target_next = tgt[cbsc_pkg::SPEED_WIDTH-1:0];
            cmd_next    = cs[cbsc_pkg::CMD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg <= 1'b0;
            target_reg  <= '0;
            cmd_reg     <= '0;
            regen_reg   <= '0;
        end
        else if (fire)
        begin
            latched_reg <= latched_next;
            target_reg  <= target_next;
            cmd_reg     <= cmd_next;
            regen_reg   <= regen_next;
        end
    end

    assign res.cruise_speed = cmd_next;
    assign res.regen_level  = regen_next;

endmodule

FILE: sv/cruise_button_speed_control.sv
// Cruise button speed control: each accepted tick word waits in the input register, and its
// result word is shown from the result register. Throughput one word per cycle unless the
// result stalls: the input register feeds the state update, whose answer lands in the result
// register; the state feeds back within that same cycle. A stalled result holds while one more
// tick word waits in the input register. Reset (rst_n low, asynchronous) clears the state, the
// configuration registers and both valid flags.
module cruise_button_speed_control (
    input  logic          clk,
    input  logic          rst_n,
    cbsc_in_if.sink       tick,
    cbsc_out_if.source    result,
    cbsc_cfg_if.sink      cfg
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    cbsc_pkg::in_word_t  s1_word_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    cbsc_pkg::out_word_t out_word_reg;
    cbsc_pkg::out_word_t core_res;
    cbsc_pkg::cfg_t      cfg_reg;
    logic                out_load;
    logic                tick_take;

    assign out_load  = s1_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !s1_valid_reg || out_load;
    assign tick_take = tick.valid && tick.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (tick_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    cbsc_pkg::CFG_TARGET_STEP:    cfg_reg.target_step    <= cfg.data;
                    cbsc_pkg::CFG_RAMP_UP_RATE:   cfg_reg.ramp_up_rate   <= cfg.data;
                    cbsc_pkg::CFG_RAMP_DOWN_RATE: cfg_reg.ramp_down_rate <= cfg.data;
                    default:                      cfg_reg                <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            s1_word_reg <= tick.data;
        end
        if (out_load)
        begin
            out_word_reg <= core_res;
        end
    end

    cbsc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (out_load),
        .word  (s1_word_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

endmodule

FILE: sv/cbsc_checker.sv
// Port-level checks for the cruise button speed control, bound to the top level.
module cbsc_checker (
    input logic         clk,
    input logic         rst_n,
    cbsc_in_if.sink     tick,
    cbsc_out_if.source  result
);

    logic [2:0]                       pending_reg;
    logic [2:0]                       pending_next;
    logic [cbsc_pkg::REGEN_WIDTH-1:0] last_regen_reg;
    logic [2:0]                       regen_new;
    logic [2:0]                       regen_old;
    logic                             tick_take;
    logic                             res_take;

    assign tick_take = tick.valid && tick.ready;
    assign res_take  = result.valid && result.ready;
    assign regen_new = {1'b0, result.data.regen_level};
    assign regen_old = {1'b0, last_regen_reg};

    always_comb
    begin
        pending_next = pending_reg;
        if (tick_take && !res_take)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (!tick_take && res_take)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            last_regen_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (res_take)
            begin
                last_regen_reg <= result.data.regen_level;
            end
        end
    end

    // at most one word in the input register and one in the result register
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more words in flight than the block can hold");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> pending_reg != 3'd0)
        else $error("result word shown with no tick word outstanding");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> tick.ready)
        else $error("tick channel stalled with an empty result register");

    // regen moves by one level per word at most
    a_regen_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |-> (regen_new == regen_old) || (regen_new == regen_old + 3'd1)
                     || (regen_old == regen_new + 3'd1))
        else $error("regen level jumped by more than one step");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.data))
        else $error("stalled result word changed");

endmodule

bind cruise_button_speed_control cbsc_checker u_cbsc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (tick),
    .result (result)
);
